// ===== rtl/core/ffba_pkg.sv =====
package ffba_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_BLOCKS_DEF   = 256;
   localparam int HEADER_BYTES_DEF = 12;
   localparam int HEAP_BYTES_DEF   = 1024 * 1024;

   // Fixed field widths
   localparam int SIZE_W  = 21;
   localparam int OFS_W   = 20;
   localparam int LIMIT_W = 21;
   localparam int STAT_W  = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RST = 21'd1048576;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_REUSED   = 3'd0,
      ST_APPENDED = 3'd1,
      ST_ZERO     = 3'd2,
      ST_NOSPACE  = 3'd3,
      ST_FULL     = 3'd4,
      ST_FREED    = 3'd5,
      ST_NOTFOUND = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WAIT
   } fsm_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic done;
   } sts_type;

endpackage

// ===== rtl/core/ffba_dp.sv =====
module ffba_dp import ffba_pkg::*; #(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [LIMIT_W-1:0] csr_wdata,
   input  op_type             in_operation,
   input  logic [SIZE_W-1:0]  in_request_size,
   input  logic [OFS_W-1:0]   in_payload_offset,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic [OFS_W-1:0]   rsp_offset,
   output status_type         rsp_status
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int RND_W  = SIZE_W + 1;
   localparam int HL_W   = $clog2(HEAP_BYTES + 1);
   localparam int EW     = (HL_W > RND_W + 1) ? HL_W : RND_W + 1;
   localparam int WORD_W = 1 + 2 * OFS_W;

   localparam logic [OFS_W-1:0] HDR_OFS  = OFS_W'(HEADER_BYTES);
   localparam logic [EW-1:0]    HDR_EXT  = EW'(HEADER_BYTES);
   localparam logic [EW-1:0]    HEAP_CAP = EW'(HEAP_BYTES);

   // Block table: {free, payload bytes, header offset}
   logic [WORD_W-1:0] blk_mem [MAX_BLOCKS];

   // Request registers
   op_type             op_ff;
   logic [RND_W-1:0]   size_ff;
   logic [OFS_W-1:0]   offs_ff;

   // Scan pipeline
   logic [CNT_W-1:0]   rd_addr_ff, rd_addr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [WORD_W-1:0]  rd_word_ff;

   // Heap bookkeeping
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SIZE_W-1:0]  bump_ff, bump_in;
   logic [LIMIT_W-1:0] limit_ff;

   // Result register
   logic [OFS_W-1:0]   res_offset_ff, res_offset_in;
   status_type         res_status_ff, res_status_in;

   logic               ent_free;
   logic [OFS_W-1:0]   ent_bytes;
   logic [OFS_W-1:0]   ent_start;
   logic [OFS_W:0]     ent_pay;
   logic               fit, owned, hit, more, miss, zero, full, rd_en;
   logic [EW-1:0]      end_sum, lim_ext, eff_lim;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [WORD_W-1:0]  wr_word;
   logic               append;

   // Decode the entry read last cycle
   assign ent_free  = rd_word_ff[WORD_W-1];
   assign ent_bytes = rd_word_ff[2*OFS_W-1:OFS_W];
   assign ent_start = rd_word_ff[OFS_W-1:0];
   assign ent_pay   = {1'b0, ent_start} + {1'b0, HDR_OFS};

   assign fit   = ent_free && ({2'b00, ent_bytes} >= size_ff);
   assign owned = (ent_pay == {1'b0, offs_ff});
   assign hit   = rd_vld_ff && ((op_ff == OP_FREE) ? owned : fit);
   assign more  = rd_addr_ff < count_ff;
   assign miss  = !rd_vld_ff && !more;
   assign zero  = (op_ff == OP_ALLOC) && (size_ff == '0);
   assign full  = count_ff >= CNT_W'(MAX_BLOCKS);
   assign rd_en = cmd.scan && more;

   assign sts.done = zero || hit || miss;

   // Append bounds against the smaller of register and heap size
   assign end_sum = EW'(bump_ff) + HDR_EXT + EW'(size_ff);
   assign lim_ext = EW'(limit_ff);
   assign eff_lim = (lim_ext > HEAP_CAP) ? HEAP_CAP : lim_ext;

   // Resolve the outcome of the request
   always_comb begin
      wr_en         = 1'b0;
      wr_idx        = rd_idx_ff;
      wr_word       = {(op_ff == OP_FREE), ent_bytes, ent_start};
      append        = 1'b0;
      res_offset_in = '0;
      res_status_in = ST_ZERO;
      if (zero) begin
         res_status_in = ST_ZERO;
      end else if (hit) begin
         wr_en = 1'b1;
         if (op_ff == OP_FREE) begin
            res_status_in = ST_FREED;
         end else begin
            res_status_in = ST_REUSED;
            res_offset_in = ent_start + HDR_OFS;
         end
      end else if (op_ff == OP_FREE) begin
         res_status_in = ST_NOTFOUND;
      end else if (full) begin
         res_status_in = ST_FULL;
      end else if (end_sum >= eff_lim) begin
         res_status_in = ST_NOSPACE;
      end else begin
         append        = 1'b1;
         wr_en         = 1'b1;
         wr_idx        = count_ff[IDX_W-1:0];
         wr_word       = {1'b0, size_ff[OFS_W-1:0], bump_ff[OFS_W-1:0]};
         res_status_in = ST_APPENDED;
         res_offset_in = bump_ff[OFS_W-1:0] + HDR_OFS;
      end
   end

   // Next values of the control registers
   always_comb begin
      rd_addr_in = rd_addr_ff;
      rd_vld_in  = rd_vld_ff;
      count_in   = count_ff;
      bump_in    = bump_ff;
      if (cmd.load) begin
         rd_addr_in = '0;
         rd_vld_in  = 1'b0;
      end else if (cmd.scan) begin
         rd_vld_in = more;
         if (more) begin
            rd_addr_in = rd_addr_ff + 1'b1;
         end
      end
      if (cmd.commit && append) begin
         count_in = count_ff + 1'b1;
         bump_in  = end_sum[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff <= '0;
         rd_vld_ff  <= 1'b0;
         count_ff   <= '0;
         bump_ff    <= '0;
         limit_ff   <= LIMIT_RST;
      end else begin
         rd_addr_ff <= rd_addr_in;
         rd_vld_ff  <= rd_vld_in;
         count_ff   <= count_in;
         bump_ff    <= bump_in;
         if (csr_wen) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= in_operation;
         size_ff <= ({1'b0, in_request_size} + RND_W'(3)) & ~RND_W'(3);
         offs_ff <= in_payload_offset;
      end
   end

   // Block table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         blk_mem[wr_idx] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= blk_mem[rd_addr_ff[IDX_W-1:0]];
         rd_idx_ff  <= rd_addr_ff[IDX_W-1:0];
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_offset_ff <= res_offset_in;
         res_status_ff <= res_status_in;
      end
   end

   assign rsp_offset = res_offset_ff;
   assign rsp_status = res_status_ff;

endmodule

// ===== rtl/core/ffba_ctrl.sv =====
module ffba_ctrl import ffba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    rsp_tready,
   output logic    rsp_tvalid,
   input  sts_type sts,
   output cmd_type cmd
);

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.done) begin
               state_in = out_free ? S_IDLE : S_WAIT;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_SCAN: begin
            cmd.scan   = !sts.done;
            cmd.commit = sts.done && out_free;
         end
         S_WAIT: begin
            cmd.commit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Hold the result until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// Channel   Dir  Signals                       Contents
// req       in   req_tvalid/tready/tdata/tuser allocate or free request
// rsp       out  rsp_tvalid/tready/tdata/tuser granted offset and status
// csr       in   csr_wen/csr_wdata             heap limit register write
//
// A request is taken, then the block table is walked one entry per cycle through its
// registered read port until a match or the end of the table; a zero size or a request
// on an empty table finishes without a walk.
// The next request is accepted the cycle after the result is registered.
// Reset clears the block count, bump pointer, controller and output valid and sets the
// heap limit to 1048576; the table is not cleared. A stalled result holds the next one.
module first_fit_block_allocator import ffba_pkg::*; #(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,  // request_size[20:0], payload_offset[40:21]
   input  logic [0:0]         req_tuser,  // operation[0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,  // result_offset[19:0]
   output logic [STAT_W-1:0]  rsp_tuser,  // status[2:0]
   input  logic               csr_wen,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   cmd_type          cmd;
   sts_type          sts;
   logic [OFS_W-1:0] res_offset;
   status_type       res_status;

   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffba_dp #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES),
      .HEAP_BYTES   (HEAP_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wen           (csr_wen),
      .csr_wdata         (csr_wdata),
      .in_operation      (op_type'(req_tuser[0])),
      .in_request_size   (req_tdata[SIZE_W-1:0]),
      .in_payload_offset (req_tdata[SIZE_W+OFS_W-1:SIZE_W]),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_offset        (res_offset),
      .rsp_status        (res_status)
   );

   assign rsp_tdata = {4'b0000, res_offset};
   assign rsp_tuser = res_status;

endmodule

// ===== rtl/core/ffba_chk.sv =====
module ffba_chk import ffba_pkg::*; #(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [23:0]       rsp_tdata,
   input logic [STAT_W-1:0] rsp_tuser
);

   // One request at a time: acceptance closes the input side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a request is in progress");

   // A stalled result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only grants carry an offset
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_REUSED && rsp_tuser != ST_APPENDED
      |-> rsp_tdata == '0)
      else $error("non-grant result carries an offset");

   // A granted offset lies past its header
   a_grant_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_REUSED || rsp_tuser == ST_APPENDED)
      |-> rsp_tdata[OFS_W-1:0] >= OFS_W'(HEADER_BYTES))
      else $error("granted offset inside header area");

   // No status code beyond not found
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_NOTFOUND)
      else $error("undefined status code");

endmodule

bind first_fit_block_allocator ffba_chk #(.HEADER_BYTES(HEADER_BYTES)) u_ffba_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
